// File: hw/rtl/cffa_pkg.sv
`timescale 1ns / 1ps
package cffa_pkg;

  // Width of a byte offset or a range length inside one chunk
  localparam int unsigned LEN_W = 23;
  // Width of a footprint before the chunk-size check
  localparam int unsigned FP_W = 24;
  // Shrink leftovers at or below this size stay with the object
  localparam int unsigned SHRINK_KEEP_BYTES = 64;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    len_t start;
    len_t len;
  } range_t;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_MODIFY = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_OK        = 3'd0,
    S_DUPLICATE = 3'd1,
    S_NOT_FOUND = 3'd2,
    S_TOO_LARGE = 3'd3,
    S_NO_CHUNKS = 3'd4,
    S_TABLE_FULL = 3'd5
  } status_e;

  // What one cell of the range chain does at the next edge
  typedef enum logic [2:0] {
    CA_KEEP,
    CA_RIGHT,
    CA_LEFT,
    CA_CARVE,
    CA_GROW,
    CA_MERGE,
    CA_FRONT,
    CA_PUT
  } cell_act_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_SHIFT,
    CM_FIT,
    CM_FREE
  } chain_mode_e;

  typedef struct packed {
    chain_mode_e mode;
    len_t        need;
    len_t        fr_start;
    len_t        fr_len;
  } chain_ctl_t;

  typedef struct packed {
    logic found;
    len_t fit_start;
    logic dropped;
  } chain_sts_t;

  typedef struct packed {
    logic fit;
    logic exact;
    logic lt;
    logic end_eq;
    logic nxt_eq;
  } cell_flags_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DECIDE,
    ST_LOAD,
    ST_FIT,
    ST_FREE,
    ST_STORE,
    ST_COMMIT
  } state_e;

endpackage

// File: hw/rtl/chunked_first_fit_object_allocator.sv
`timescale 1ns / 1ps
// Channel   | Ports                                           | Transfer
// command   | start, busy, command_i, object_id_i, payload_*  | start & !busy
// result    | done_o, status_o .. range_dropped_o             | done_o, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata    | psel&penable&pwrite
//
// One command at a time. The sequencer scans the object table, then reads the
// matching record and decides. Each free-list pass loads a chunk's list into
// the cell row and works on it; after a fit that found room or after a free
// it stores the list back. A fit pass tries the active chunk first and moves on
// through the following chunks up to the last; a free pass returns the old place.
// Every command ends in a commit step.
// Reset is asynchronous; every chunk then reads as one whole free range.
// The result receiver cannot stall; busy stays high until the result strobe.
module chunked_first_fit_object_allocator import cffa_pkg::*; #(
  parameter int unsigned BLOCK_BYTES      = 4194304,
  parameter int unsigned HEADER_BYTES     = 64,
  parameter int unsigned MAX_CHUNKS       = 16,
  parameter int unsigned RANGES_PER_CHUNK = 16,
  parameter int unsigned MAX_OBJECTS      = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [63:0] object_id_i,
  input  logic [22:0] payload_bytes_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  chunk_number_o,
  output logic [21:0] byte_offset_o,
  output logic [22:0] stored_payload_bytes_o,
  output logic [31:0] object_version_o,
  output logic        is_deleted_o,
  output logic        soft_limit_warning_o,
  output logic        range_dropped_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CH_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned OI_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int unsigned SC_W = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned CW   = $clog2(RANGES_PER_CHUNK + 1);
  localparam int unsigned RDEP = MAX_CHUNKS * RANGES_PER_CHUNK;
  localparam int unsigned RA_W = $clog2(RDEP);
  localparam int unsigned PL_W = CH_W + 2 * LEN_W;
  localparam int unsigned MT_W = 33;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(MAX_CHUNKS - 1);

  function automatic logic [FP_W-1:0] fp(input len_t p);
    logic [FP_W-1:0] s;
    s = FP_W'(p) + FP_W'(HEADER_BYTES + 7);
    return {s[FP_W-1:3], 3'b000};
  endfunction

  state_e state_q, state_d;

  cmd_e          cmd_q;
  logic [63:0]   id_q;
  len_t          pay_q;
  logic [SC_W-1:0] scan_cnt_q;
  logic          sc_vld_q;
  logic [OI_W-1:0] sc_idx_q, hit_idx_q, free_idx_q, obj_idx_q;
  logic          hit_q, free_found_q;
  logic [63:0]   key_rd_q;
  logic          vld_rd_q;
  logic [PL_W-1:0] place_rd_q;
  logic [MT_W-1:0] meta_rd_q;
  logic [CH_W-1:0] rec_chunk_q, fchunk_q, active_q, cur_q;
  len_t          rec_off_q, rec_pay_q, fstart_q, flen_q, need_q;
  logic [31:0]   rec_ver_q;
  logic          rec_del_q, obj_present_q, commit_q, alloc_pend_q, free_pend_q;
  status_e       status_q;
  logic          warn_q, drop_q;
  logic [CW-1:0] ld_cnt_q, st_cnt_q;
  logic [CW-1:0] cnt_q [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] init_q;
  logic [MAX_OBJECTS-1:0] valid_q;
  logic [4:0]    limit_q;

  logic          done_q;
  logic [2:0]    status_oq;
  logic [3:0]    chunk_oq;
  logic [21:0]   off_oq;
  len_t          pay_oq;
  logic [31:0]   ver_oq;
  logic          del_oq, warn_oq, drop_oq;

  logic [63:0]   key_mem   [MAX_OBJECTS];
  logic [PL_W-1:0] place_mem [MAX_OBJECTS];
  logic [MT_W-1:0] meta_mem  [MAX_OBJECTS];
  range_t        rng_mem   [RDEP];
  range_t        rng_rd_q;

  chain_ctl_t    ctl;
  chain_sts_t    sts;
  range_t        load_data, store_data;
  logic          cnt_ld, rng_we;
  logic [CW-1:0] chain_cnt;
  logic [RA_W-1:0] rng_ra, rng_wa;

  // Fields of the record read after the scan
  logic [CH_W-1:0] rd_chunk;
  len_t          rd_off, rd_pay;
  logic          rd_del;
  logic [31:0]   rd_ver;
  assign {rd_chunk, rd_off, rd_pay} = place_rd_q;
  assign {rd_del, rd_ver} = meta_rd_q;

  // Decision after the record read
  status_e       dec_status;
  logic          dec_alloc, dec_free, dec_commit, dec_del;
  len_t          dec_fstart, dec_flen, dec_pay;
  logic [31:0]   dec_ver;
  logic [FP_W-1:0] new_fp, old_fp, left_fp;

  always_comb begin
    new_fp = fp(pay_q);
    old_fp = fp(rd_pay);
    left_fp = old_fp - new_fp;
    dec_status = S_OK;
    dec_alloc = 1'b0;
    dec_free = 1'b0;
    dec_commit = 1'b0;
    dec_del = rd_del;
    dec_fstart = rd_off;
    dec_flen = LEN_W'(old_fp);
    dec_pay = rd_pay;
    dec_ver = rd_ver;
    case (cmd_q)
      CMD_CREATE: begin
        if (hit_q) dec_status = S_DUPLICATE;
        else if (!free_found_q) dec_status = S_TABLE_FULL;
        else if (new_fp > FP_W'(BLOCK_BYTES)) dec_status = S_TOO_LARGE;
        else dec_alloc = 1'b1;
      end
      CMD_MODIFY: begin
        if (!hit_q || rd_del) begin
          dec_status = S_NOT_FOUND;
        end else if (new_fp <= old_fp) begin
          dec_pay = pay_q;
          dec_ver = rd_ver + 32'd1;
          dec_commit = 1'b1;
          dec_free = left_fp > FP_W'(SHRINK_KEEP_BYTES);
          dec_fstart = LEN_W'(FP_W'(rd_off) + new_fp);
          dec_flen = LEN_W'(left_fp);
        end else if (new_fp > FP_W'(BLOCK_BYTES)) begin
          dec_status = S_TOO_LARGE;
        end else begin
          dec_alloc = 1'b1;
          dec_free = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (!hit_q || rd_del) begin
          dec_status = S_NOT_FOUND;
        end else begin
          dec_del = 1'b1;
          dec_ver = rd_ver + 32'd1;
          dec_commit = 1'b1;
          dec_free = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (!hit_q) dec_status = S_NOT_FOUND;
      end
      default: dec_status = S_NOT_FOUND;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_SCAN;
      ST_SCAN:   if (scan_cnt_q == SC_W'(MAX_OBJECTS)) state_d = ST_READ;
      ST_READ:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = (dec_alloc || dec_free) ? ST_LOAD : ST_COMMIT;
      ST_LOAD: begin
        if (ld_cnt_q == CW'(RANGES_PER_CHUNK)) state_d = alloc_pend_q ? ST_FIT : ST_FREE;
      end
      ST_FIT: begin
        if (sts.found) state_d = ST_STORE;
        else if (cur_q == LAST_CH) state_d = ST_COMMIT;
        else state_d = ST_LOAD;
      end
      ST_FREE:   state_d = ST_STORE;
      ST_STORE: begin
        if (st_cnt_q == CW'(RANGES_PER_CHUNK - 1)) state_d = free_pend_q ? ST_LOAD : ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    ctl.mode = CM_HOLD;
    ctl.need = need_q;
    ctl.fr_start = fstart_q;
    ctl.fr_len = flen_q;
    cnt_ld = 1'b0;
    rng_we = 1'b0;
    case (state_q)
      ST_LOAD: begin
        cnt_ld = ld_cnt_q == '0;
        if (ld_cnt_q != '0) ctl.mode = CM_SHIFT;
      end
      ST_FIT:   ctl.mode = CM_FIT;
      ST_FREE:  ctl.mode = CM_FREE;
      ST_STORE: begin
        ctl.mode = CM_SHIFT;
        rng_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign rng_ra = RA_W'(cur_q) * RA_W'(RANGES_PER_CHUNK) + RA_W'(ld_cnt_q);
  assign rng_wa = RA_W'(cur_q) * RA_W'(RANGES_PER_CHUNK) + RA_W'(st_cnt_q);

  // Untouched chunks read as one whole-chunk range
  always_comb begin
    if (init_q[cur_q]) load_data = rng_rd_q;
    else if (ld_cnt_q == CW'(1)) load_data = '{start: '0, len: LEN_W'(BLOCK_BYTES)};
    else load_data = '0;
  end

  cffa_range_chain #(.RPC(RANGES_PER_CHUNK)) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .load_data_i (load_data),
    .cnt_ld_i    (cnt_ld),
    .cnt_i       (cnt_q[cur_q]),
    .cnt_o       (chain_cnt),
    .store_data_o(store_data),
    .sts_o       (sts)
  );

  // Free range memory
  always_ff @(posedge clk_i) begin
    if (rng_we) rng_mem[rng_wa] <= store_data;
    rng_rd_q <= rng_mem[rng_ra];
  end

  // Object table memories
  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMMIT && commit_q) begin
      if (cmd_q == CMD_CREATE) key_mem[obj_idx_q] <= id_q;
      place_mem[obj_idx_q] <= {rec_chunk_q, rec_off_q, rec_pay_q};
      meta_mem[obj_idx_q] <= {rec_del_q, rec_ver_q};
    end
    key_rd_q <= key_mem[scan_cnt_q[OI_W-1:0]];
    place_rd_q <= place_mem[hit_idx_q];
    meta_rd_q <= meta_mem[hit_idx_q];
  end

  // Sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q <= CMD_LOOKUP;
      id_q <= '0;
      pay_q <= '0;
      scan_cnt_q <= '0;
      sc_vld_q <= 1'b0;
      sc_idx_q <= '0;
      vld_rd_q <= 1'b0;
      hit_q <= 1'b0;
      hit_idx_q <= '0;
      free_found_q <= 1'b0;
      free_idx_q <= '0;
      obj_idx_q <= '0;
      rec_chunk_q <= '0;
      rec_off_q <= '0;
      rec_pay_q <= '0;
      rec_ver_q <= '0;
      rec_del_q <= 1'b0;
      obj_present_q <= 1'b0;
      commit_q <= 1'b0;
      alloc_pend_q <= 1'b0;
      free_pend_q <= 1'b0;
      fchunk_q <= '0;
      fstart_q <= '0;
      flen_q <= '0;
      need_q <= '0;
      status_q <= S_OK;
      warn_q <= 1'b0;
      drop_q <= 1'b0;
      active_q <= '0;
      cur_q <= '0;
      ld_cnt_q <= '0;
      st_cnt_q <= '0;
      for (int c = 0; c < MAX_CHUNKS; c++) cnt_q[c] <= CW'(1);
      init_q <= '0;
      valid_q <= '0;
      done_q <= 1'b0;
      status_oq <= '0;
      chunk_oq <= '0;
      off_oq <= '0;
      pay_oq <= '0;
      ver_oq <= '0;
      del_oq <= 1'b0;
      warn_oq <= 1'b0;
      drop_oq <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= 1'b0;
      sc_vld_q <= 1'b0;
      vld_rd_q <= valid_q[scan_cnt_q[OI_W-1:0]];
      sc_idx_q <= scan_cnt_q[OI_W-1:0];
      if (state_q != ST_LOAD) ld_cnt_q <= '0;
      if (state_q != ST_STORE) st_cnt_q <= '0;

      // Record the scan result of the previous read
      if (sc_vld_q) begin
        if (vld_rd_q && key_rd_q == id_q && !hit_q) begin
          hit_q <= 1'b1;
          hit_idx_q <= sc_idx_q;
        end
        if (!vld_rd_q && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q <= sc_idx_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd_e'(command_i);
            id_q <= object_id_i;
            pay_q <= payload_bytes_i;
            scan_cnt_q <= '0;
            hit_q <= 1'b0;
            free_found_q <= 1'b0;
            warn_q <= 1'b0;
            drop_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_cnt_q != SC_W'(MAX_OBJECTS)) begin
            sc_vld_q <= 1'b1;
            scan_cnt_q <= scan_cnt_q + SC_W'(1);
          end
        end
        ST_DECIDE: begin
          status_q <= dec_status;
          obj_present_q <= hit_q;
          obj_idx_q <= (cmd_q == CMD_CREATE) ? free_idx_q : hit_idx_q;
          rec_chunk_q <= rd_chunk;
          rec_off_q <= rd_off;
          rec_pay_q <= dec_pay;
          rec_ver_q <= dec_ver;
          rec_del_q <= dec_del;
          commit_q <= dec_commit;
          alloc_pend_q <= dec_alloc;
          free_pend_q <= dec_free;
          fchunk_q <= rd_chunk;
          fstart_q <= dec_fstart;
          flen_q <= dec_flen;
          need_q <= LEN_W'(new_fp);
          cur_q <= dec_alloc ? active_q : rd_chunk;
        end
        ST_LOAD: ld_cnt_q <= ld_cnt_q + CW'(1);
        ST_FIT: begin
          if (sts.found) begin
            alloc_pend_q <= 1'b0;
            rec_chunk_q <= cur_q;
            rec_off_q <= sts.fit_start;
            rec_pay_q <= pay_q;
            rec_ver_q <= (cmd_q == CMD_CREATE) ? 32'd1 : rec_ver_q + 32'd1;
            rec_del_q <= 1'b0;
            obj_present_q <= 1'b1;
            commit_q <= 1'b1;
          end else if (cur_q == LAST_CH) begin
            status_q <= S_NO_CHUNKS;
            alloc_pend_q <= 1'b0;
            free_pend_q <= 1'b0;
          end else begin
            active_q <= active_q + CH_W'(1);
            cur_q <= cur_q + CH_W'(1);
            if ((9'(active_q) + 9'd1) >= 9'(limit_q)) warn_q <= 1'b1;
          end
        end
        ST_FREE: begin
          free_pend_q <= 1'b0;
          drop_q <= sts.dropped;
        end
        ST_STORE: begin
          st_cnt_q <= st_cnt_q + CW'(1);
          if (st_cnt_q == CW'(RANGES_PER_CHUNK - 1)) begin
            cnt_q[cur_q] <= chain_cnt;
            init_q[cur_q] <= 1'b1;
            if (free_pend_q) cur_q <= fchunk_q;
          end
        end
        ST_COMMIT: begin
          if (commit_q && cmd_q == CMD_CREATE) valid_q[obj_idx_q] <= 1'b1;
          done_q <= 1'b1;
          status_oq <= status_q;
          chunk_oq <= obj_present_q ? 4'(rec_chunk_q) : '0;
          off_oq <= obj_present_q ? 22'(rec_off_q) : '0;
          pay_oq <= obj_present_q ? rec_pay_q : '0;
          ver_oq <= obj_present_q ? rec_ver_q : '0;
          del_oq <= obj_present_q & rec_del_q;
          warn_oq <= warn_q;
          drop_oq <= drop_q;
        end
        default: ;
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 5'd16;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[4:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {27'd0, limit_q};
  assign pready = 1'b1;

  assign busy = state_q != ST_IDLE;
  assign done_o = done_q;
  assign status_o = status_oq;
  assign chunk_number_o = chunk_oq;
  assign byte_offset_o = off_oq;
  assign stored_payload_bytes_o = pay_oq;
  assign object_version_o = ver_oq;
  assign is_deleted_o = del_oq;
  assign soft_limit_warning_o = warn_oq;
  assign range_dropped_o = drop_oq;

`ifndef NO_ASSERTIONS
  // The result strobe comes only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // An accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command not started");

  // The cell row never holds more ranges than it has cells
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_cnt <= CW'(RANGES_PER_CHUNK)) else $error("free list count overflow");

  // A successful create reports a fresh version
  a_create_ver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == S_OK && cmd_q == CMD_CREATE) |-> object_version_o == 32'd1)
    else $error("created object has wrong version");
`endif

endmodule

// File: hw/rtl/cffa_range_cell.sv
`timescale 1ns / 1ps
module cffa_range_cell import cffa_pkg::*; (
  input  logic        clk_i,
  input  cell_act_e   act_i,
  input  range_t      left_i,
  input  range_t      right_i,
  input  chain_ctl_t  ctl_i,
  output range_t      rng_o,
  output cell_flags_t flg_o
);

  range_t rng_q, rng_d;

  // Compare the held range against the request
  always_comb begin
    flg_o.fit    = rng_q.len >= ctl_i.need;
    flg_o.exact  = rng_q.len == ctl_i.need;
    flg_o.lt     = rng_q.start < ctl_i.fr_start;
    flg_o.end_eq = ({1'b0, rng_q.start} + {1'b0, rng_q.len}) == {1'b0, ctl_i.fr_start};
    flg_o.nxt_eq = ({1'b0, ctl_i.fr_start} + {1'b0, ctl_i.fr_len}) == {1'b0, rng_q.start};
  end

  // Apply the action chosen by the chain
  always_comb begin
    rng_d = rng_q;
    case (act_i)
      CA_KEEP:  rng_d = rng_q;
      CA_RIGHT: rng_d = right_i;
      CA_LEFT:  rng_d = left_i;
      CA_CARVE: begin
        rng_d.start = rng_q.start + ctl_i.need;
        rng_d.len   = rng_q.len - ctl_i.need;
      end
      CA_GROW:  rng_d.len = rng_q.len + ctl_i.fr_len;
      CA_MERGE: rng_d.len = rng_q.len + ctl_i.fr_len + right_i.len;
      CA_FRONT: begin
        rng_d.start = ctl_i.fr_start;
        rng_d.len   = rng_q.len + ctl_i.fr_len;
      end
      CA_PUT: begin
        rng_d.start = ctl_i.fr_start;
        rng_d.len   = ctl_i.fr_len;
      end
      default:  rng_d = rng_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rng_q <= rng_d;
  end

  assign rng_o = rng_q;

endmodule

// File: hw/rtl/cffa_range_chain.sv
`timescale 1ns / 1ps
module cffa_range_chain import cffa_pkg::*; #(
  parameter int unsigned RPC = 16,
  localparam int unsigned CW = $clog2(RPC + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  chain_ctl_t    ctl_i,
  input  range_t        load_data_i,
  input  logic          cnt_ld_i,
  input  logic [CW-1:0] cnt_i,
  output logic [CW-1:0] cnt_o,
  output range_t        store_data_o,
  output chain_sts_t    sts_o
);

  range_t      rng   [RPC];
  range_t      left  [RPC];
  range_t      right [RPC];
  cell_flags_t flg   [RPC];
  cell_act_e   act   [RPC];
  logic [CW-1:0] cnt_q, cnt_d;

  // Wire neighbors: the last cell takes load data from the memory side
  for (genvar g = 0; g < RPC; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left[g] = '0;
    end else begin : g_mid
      assign left[g] = rng[g-1];
    end
    if (g == RPC - 1) begin : g_last
      assign right[g] = load_data_i;
    end else begin : g_inner
      assign right[g] = rng[g+1];
    end
    cffa_range_cell u_cell (
      .clk_i  (clk_i),
      .act_i  (act[g]),
      .left_i (left[g]),
      .right_i(right[g]),
      .ctl_i  (ctl_i),
      .rng_o  (rng[g]),
      .flg_o  (flg[g])
    );
  end

  // Choose each cell's action from the flags of the row
  always_comb begin
    logic [RPC-1:0] vld, ltv, hit, seen_before, prev_r, next_r, pos_r;
    logic           seen, exact_hit, wp, wn, full;
    len_t           fstart;
    vld = '0; ltv = '0; hit = '0; seen_before = '0;
    prev_r = '0; next_r = '0; pos_r = '0;
    seen = 1'b0; exact_hit = 1'b0; wp = 1'b0; wn = 1'b0;
    fstart = '0;
    full = cnt_q >= CW'(RPC);
    for (int i = 0; i < RPC; i++) begin
      vld[i] = CW'(i) < cnt_q;
      ltv[i] = flg[i].lt & vld[i];
    end
    for (int i = 0; i < RPC; i++) begin
      seen_before[i] = seen;
      hit[i] = flg[i].fit & vld[i] & ~seen;
      seen = seen | (flg[i].fit & vld[i]);
      if (hit[i]) begin
        exact_hit = flg[i].exact;
        fstart = rng[i].start;
      end
    end
    for (int i = 0; i < RPC; i++) begin
      prev_r[i] = ltv[i] & ~((i + 1 < RPC) ? ltv[(i + 1) % RPC] : 1'b0);
      pos_r[i]  = ~ltv[i] & ((i == 0) ? 1'b1 : ltv[(i + RPC - 1) % RPC]);
      next_r[i] = pos_r[i] & vld[i];
      wp = wp | (prev_r[i] & flg[i].end_eq);
      wn = wn | (next_r[i] & flg[i].nxt_eq);
    end

    cnt_d = cnt_q;
    sts_o.found = 1'b0;
    sts_o.fit_start = fstart;
    sts_o.dropped = 1'b0;
    for (int i = 0; i < RPC; i++) act[i] = CA_KEEP;

    case (ctl_i.mode)
      CM_HOLD: ;
      CM_SHIFT: begin
        for (int i = 0; i < RPC; i++) act[i] = CA_RIGHT;
      end
      CM_FIT: begin
        sts_o.found = seen;
        for (int i = 0; i < RPC; i++) begin
          if (hit[i]) act[i] = exact_hit ? CA_RIGHT : CA_CARVE;
          else if (seen_before[i] && exact_hit) act[i] = CA_RIGHT;
        end
        if (seen && exact_hit) cnt_d = cnt_q - CW'(1);
      end
      CM_FREE: begin
        if (wp && wn) begin
          for (int i = 0; i < RPC; i++) begin
            if (prev_r[i]) act[i] = CA_MERGE;
            else if (!ltv[i]) act[i] = CA_RIGHT;
          end
          cnt_d = cnt_q - CW'(1);
        end else if (wp) begin
          for (int i = 0; i < RPC; i++) if (prev_r[i]) act[i] = CA_GROW;
        end else if (wn) begin
          for (int i = 0; i < RPC; i++) if (next_r[i]) act[i] = CA_FRONT;
        end else if (full) begin
          sts_o.dropped = 1'b1;
        end else begin
          for (int i = 0; i < RPC; i++) begin
            if (pos_r[i]) act[i] = CA_PUT;
            else if (!ltv[i]) act[i] = CA_LEFT;
          end
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: ;
    endcase
    if (cnt_ld_i) cnt_d = cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;
  assign store_data_o = rng[0];

endmodule
